// File: design/tea_pkg.sv
`timescale 1ns / 1ps

package tea_pkg;

    localparam int ROUNDS    = 32;
    localparam int STAGES    = 2 * ROUNDS;
    localparam int WORD_W    = 32;
    localparam int CFG_IDX_W = 2;

    localparam logic [WORD_W-1:0] DELTA = 32'h9e37_79b9;

    localparam logic OP_ENCRYPT = 1'b0;
    localparam logic OP_DECRYPT = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_KEY0 = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KEY1 = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_KEY2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_KEY3 = 2'd3;

    typedef struct packed {
        logic              op;
        logic [WORD_W-1:0] left;
        logic [WORD_W-1:0] right;
    } tea_item_t;

    typedef struct packed {
        logic [WORD_W-1:0] w0;
        logic [WORD_W-1:0] w1;
        logic [WORD_W-1:0] w2;
        logic [WORD_W-1:0] w3;
    } tea_key_t;

    function automatic logic [WORD_W-1:0] tea_mix(
        input logic [WORD_W-1:0] v,
        input logic [WORD_W-1:0] acc,
        input logic [WORD_W-1:0] ka,
        input logic [WORD_W-1:0] kb
    );
        tea_mix = ((v << 4) + ka) ^ (v + acc) ^ ((v >> 5) + kb);
    endfunction

    // Running sum seen by round r, counted from zero in the forward direction.
    function automatic logic [WORD_W-1:0] enc_sum(input int r);
        logic [63:0] prod;
        prod = 64'(DELTA) * 64'(r + 1);
        enc_sum = prod[WORD_W-1:0];
    endfunction

    function automatic logic [WORD_W-1:0] dec_sum(input int r);
        logic [63:0] prod;
        prod = 64'(DELTA) * 64'(ROUNDS - r);
        dec_sum = prod[WORD_W-1:0];
    endfunction

endpackage

// File: design/tea_block_cipher.sv
`timescale 1ns / 1ps

// Channel   Dir  Signals                    Contents (lowest bit up)
// s_axis    in   tvalid tready tdata tuser  tdata: block_left, block_right; tuser: op
// m_axis    out  tvalid tready tdata        tdata: result_left, result_right
// cfg       in   cfg_wr_en cfg_index cfg_wdata  key words 0 to 3
//
// One block enters per cycle while the pipeline is not held; a result passes through
// one register stage per half round of the 32 rounds before it is offered.
// The whole pipeline holds while the output register is full and not taken.
// Reset clears all stage valid bits and the key words to zero.

module tea_block_cipher (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [63:0]                   s_axis_tdata,  // block_left, block_right
    input  logic                          s_axis_tuser,  // op
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [63:0]                   m_axis_tdata,  // result_left, result_right
    input  logic                          cfg_wr_en,
    input  logic [tea_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [tea_pkg::WORD_W-1:0]    cfg_wdata
);
    import tea_pkg::*;

    tea_key_t         key;
    logic             advance;
    logic [STAGES:0]  valid;
    tea_item_t        item [0:STAGES];

    tea_keys u_keys (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .key       (key)
    );

    assign advance       = !valid[STAGES] || m_axis_tready;
    assign s_axis_tready = advance;

    assign valid[0]      = s_axis_tvalid;
    assign item[0].op    = s_axis_tuser;
    assign item[0].left  = s_axis_tdata[WORD_W-1:0];
    assign item[0].right = s_axis_tdata[2*WORD_W-1:WORD_W];

    for (genvar j = 0; j < STAGES; j++)
    begin : g_stage
        localparam logic [WORD_W-1:0] SUM_ENC = enc_sum(j / 2);
        localparam logic [WORD_W-1:0] SUM_DEC = dec_sum(j / 2);
        localparam logic              SECOND  = ((j % 2) == 1);

        tea_half u_half (
            .clk       (clk),
            .rst_n     (rst_n),
            .advance   (advance),
            .second    (SECOND),
            .sum_enc   (SUM_ENC),
            .sum_dec   (SUM_DEC),
            .key       (key),
            .in_valid  (valid[j]),
            .in_item   (item[j]),
            .out_valid (valid[j+1]),
            .out_item  (item[j+1])
        );
    end

    assign m_axis_tvalid = valid[STAGES];
    assign m_axis_tdata  = {item[STAGES].right, item[STAGES].left};

`ifndef ASSERT_OFF
    a_stall_blocks_input : assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
        else $error("input taken while the pipeline is stalled");

    a_transfer_enters : assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> valid[1])
        else $error("accepted block did not enter the first stage");

    a_stall_holds_valids : assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(valid[STAGES:1]))
        else $error("stage valid bits moved during a stall");
`endif

endmodule

// File: design/tea_keys.sv
`timescale 1ns / 1ps

module tea_keys (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic [tea_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [tea_pkg::WORD_W-1:0]    cfg_wdata,
    output tea_pkg::tea_key_t             key
);
    import tea_pkg::*;

    tea_key_t key_reg;
    tea_key_t key_next;

    always_comb
    begin
        key_next = key_reg;
        if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_KEY0: key_next.w0 = cfg_wdata;
                REG_KEY1: key_next.w1 = cfg_wdata;
                REG_KEY2: key_next.w2 = cfg_wdata;
                REG_KEY3: key_next.w3 = cfg_wdata;
                default:  key_next = key_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_reg <= '0;
        end
        else
        begin
            key_reg <= key_next;
        end
    end

    assign key = key_reg;

endmodule

// File: design/tea_half.sv
`timescale 1ns / 1ps

module tea_half (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       advance,
    input  logic                       second,
    input  logic [tea_pkg::WORD_W-1:0] sum_enc,
    input  logic [tea_pkg::WORD_W-1:0] sum_dec,
    input  tea_pkg::tea_key_t          key,
    input  logic                       in_valid,
    input  tea_pkg::tea_item_t         in_item,
    output logic                       out_valid,
    output tea_pkg::tea_item_t         out_item
);
    import tea_pkg::*;

    logic              valid_reg;
    tea_item_t         item_reg;
    tea_item_t         item_next;
    logic              mix_right;
    logic [WORD_W-1:0] mix_in;
    logic [WORD_W-1:0] mix_sum;
    logic [WORD_W-1:0] ka;
    logic [WORD_W-1:0] kb;
    logic [WORD_W-1:0] mixed;

    // Encryption updates the left word first, decryption undoes the right
    // word first; the mix runs on the opposite word with its key pair.
    always_comb
    begin
        mix_right = (in_item.op == OP_ENCRYPT) ? !second : second;
        mix_in    = mix_right ? in_item.right : in_item.left;
        ka        = mix_right ? key.w0 : key.w2;
        kb        = mix_right ? key.w1 : key.w3;
        mix_sum   = (in_item.op == OP_ENCRYPT) ? sum_enc : sum_dec;
        mixed     = tea_mix(mix_in, mix_sum, ka, kb);
        item_next = in_item;
        if (in_item.op == OP_ENCRYPT)
        begin
            if (mix_right)
                item_next.left = in_item.left + mixed;
            else
                item_next.right = in_item.right + mixed;
        end
        else
        begin
            if (mix_right)
                item_next.left = in_item.left - mixed;
            else
                item_next.right = in_item.right - mixed;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            item_reg <= item_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;

endmodule

// File: tb/sv/testbench.sv
`timescale 1ns / 1ps

module testbench;

    import tea_pkg::*;

    localparam int          NUM_ROUNDS  = 32;
    localparam logic [31:0] GOLDEN      = 32'h9e37_79b9;
    localparam int          LATENCY     = 64;
    localparam int          CYCLE_LIMIT = 500000;

    typedef struct packed {
        logic [31:0] left;
        logic [31:0] right;
    } block_t;

    logic                 clk;
    logic                 rst_n;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    logic [63:0]          s_axis_tdata;
    logic                 s_axis_tuser;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;
    logic [63:0]          m_axis_tdata;
    logic                 cfg_wr_en;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [WORD_W-1:0]    cfg_wdata;

    logic [31:0] key_w [4];
    block_t      expected_blocks[$];
    block_t      wanted;
    bit          tx_idle_en;
    bit          rx_idle_en;
    int          hold_req;
    int          errors;
    int          cycles;
    int          n_encrypt;
    int          n_decrypt;
    int          n_results;
    int          n_keys;

    tea_block_cipher i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d results outstanding", cycles,
                     expected_blocks.size());
            $display("Mismatches found");
            $finish;
        end
    end

    function automatic logic [31:0] half_round(input logic [31:0] v, input logic [31:0] acc,
                                               input logic [31:0] ka, input logic [31:0] kb);
        return ((v << 4) + ka) ^ (v + acc) ^ ((v >> 5) + kb);
    endfunction

    function automatic block_t predict_tea(input logic op, input block_t blk);
        logic [31:0] lw;
        logic [31:0] rw;
        logic [31:0] acc;
        lw = blk.left;
        rw = blk.right;
        if (op == OP_ENCRYPT)
        begin
            acc = '0;
            for (int r = 0; r < NUM_ROUNDS; r++)
            begin
                acc += GOLDEN;
                lw += half_round(rw, acc, key_w[0], key_w[1]);
                rw += half_round(lw, acc, key_w[2], key_w[3]);
            end
        end
        else
        begin
            acc = 32'(GOLDEN * 32'(NUM_ROUNDS));
            for (int r = 0; r < NUM_ROUNDS; r++)
            begin
                rw -= half_round(lw, acc, key_w[2], key_w[3]);
                lw -= half_round(rw, acc, key_w[0], key_w[1]);
                acc -= GOLDEN;
            end
        end
        return '{left: lw, right: rw};
    endfunction

    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 7))
            0: return 32'h0000_0000;
            1: return 32'hffff_ffff;
            default: return $urandom();
        endcase
    endfunction

    // Called at a rising edge; returns at the rising edge of the transfer.
    task automatic send_block(input logic op, input block_t blk);
        int gap;
        gap = (tx_idle_en && $urandom_range(0, 5) == 0) ? $urandom_range(1, 19) : 0;
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {blk.right, blk.left};
        s_axis_tuser  <= op;
        @(negedge clk);
        while (!s_axis_tready)
            @(negedge clk);
        expected_blocks.push_back(predict_tea(op, blk));
        if (op == OP_ENCRYPT)
            n_encrypt++;
        else
            n_decrypt++;
        @(posedge clk);
    endtask

    task automatic stop_sending();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic wait_for_results();
        while (expected_blocks.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic load_key(input logic [31:0] k0, input logic [31:0] k1,
                            input logic [31:0] k2, input logic [31:0] k3);
        logic [31:0] words [4];
        logic [CFG_IDX_W-1:0] regs [4];
        words = '{k0, k1, k2, k3};
        regs  = '{REG_KEY0, REG_KEY1, REG_KEY2, REG_KEY3};
        for (int i = 0; i < 4; i++)
        begin
            cfg_wr_en <= 1'b1;
            cfg_index <= regs[i];
            cfg_wdata <= words[i];
            @(posedge clk);
            key_w[regs[i]] = words[i];
        end
        cfg_wr_en <= 1'b0;
        @(posedge clk);
        n_keys++;
    endtask

    task automatic test_zero_key();
        send_block(OP_ENCRYPT, '{left: 32'h0, right: 32'h0});
        send_block(OP_ENCRYPT, '{left: 32'hffff_ffff, right: 32'hffff_ffff});
        send_block(OP_DECRYPT, '{left: 32'h0, right: 32'h0});
        send_block(OP_DECRYPT, '{left: 32'hffff_ffff, right: 32'hffff_ffff});
        stop_sending();
        wait_for_results();
    endtask

    task automatic test_field_extremes();
        block_t pats [4];
        block_t plain;
        pats = '{'{left: 32'h0, right: 32'hffff_ffff},
                 '{left: 32'hffff_ffff, right: 32'h0},
                 '{left: 32'h5555_5555, right: 32'haaaa_aaaa},
                 '{left: 32'haaaa_aaaa, right: 32'h5555_5555}};
        load_key(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
        for (int i = 0; i < 4; i++)
        begin
            send_block(OP_ENCRYPT, pats[i]);
            send_block(OP_DECRYPT, pats[i]);
        end
        stop_sending();
        wait_for_results();
        load_key(32'h0123_4567, 32'h89ab_cdef, 32'hfedc_ba98, 32'h7654_3210);
        plain = '{left: 32'hdead_beef, right: 32'h0bad_f00d};
        send_block(OP_ENCRYPT, plain);
        send_block(OP_DECRYPT, predict_tea(OP_ENCRYPT, plain));
        stop_sending();
        wait_for_results();
    endtask

    task automatic test_random_keys(input int phases, input int per_phase);
        block_t plain;
        for (int p = 0; p < phases; p++)
        begin
            case (p)
                0: load_key(32'h0, 32'h0, 32'h0, 32'h0);
                1: load_key(32'hffff_ffff, 32'h0, 32'hffff_ffff, 32'h0);
                default: load_key(rand_word(), rand_word(), rand_word(), rand_word());
            endcase
            for (int n = 0; n < per_phase; n++)
            begin
                // Roughly one in four is an encrypt followed by the decrypt of its output.
                if ($urandom_range(0, 3) == 0)
                begin
                    plain = '{left: rand_word(), right: rand_word()};
                    send_block(OP_ENCRYPT, plain);
                    send_block(OP_DECRYPT, predict_tea(OP_ENCRYPT, plain));
                    n++;
                end
                else
                begin
                    send_block(1'($urandom_range(0, 1)), '{left: rand_word(), right: rand_word()});
                end
            end
            stop_sending();
            wait_for_results();
        end
    endtask

    task automatic test_full_pipeline_stall();
        load_key($urandom(), $urandom(), $urandom(), $urandom());
        tx_idle_en = 1'b0;
        hold_req   = 400;
        for (int n = 0; n < 160; n++)
            send_block(1'($urandom_range(0, 1)), '{left: $urandom(), right: $urandom()});
        stop_sending();
        wait_for_results();
        tx_idle_en = 1'b1;
    endtask

    task automatic test_steady_stream(input int count);
        load_key($urandom(), $urandom(), $urandom(), $urandom());
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        for (int n = 0; n < count; n++)
            send_block(1'($urandom_range(0, 1)), '{left: rand_word(), right: rand_word()});
        stop_sending();
    endtask

    initial
    begin
        int stall;
        m_axis_tready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req > 0)
            begin
                stall    = hold_req;
                hold_req = 0;
            end
            else if (rx_idle_en && $urandom_range(0, 9) == 0)
            begin
                stall = $urandom_range(1, 19);
            end
            else
            begin
                stall = 0;
            end
            if (stall > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
        end
    end

    always @(negedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (expected_blocks.size() == 0)
            begin
                $display("%0t: result with none expected, actual %h", $time, m_axis_tdata);
                errors++;
            end
            else
            begin
                wanted = expected_blocks.pop_front();
                n_results++;
                if (m_axis_tdata[31:0] !== wanted.left)
                begin
                    $display("%0t: result_left expected %h actual %h", $time, wanted.left,
                             m_axis_tdata[31:0]);
                    errors++;
                end
                if (m_axis_tdata[63:32] !== wanted.right)
                begin
                    $display("%0t: result_right expected %h actual %h", $time, wanted.right,
                             m_axis_tdata[63:32]);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        clk           = 1'b0;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = OP_ENCRYPT;
        cfg_wr_en     = 1'b0;
        cfg_index     = REG_KEY0;
        cfg_wdata     = '0;
        key_w         = '{32'h0, 32'h0, 32'h0, 32'h0};
        tx_idle_en    = 1'b1;
        rx_idle_en    = 1'b1;
        hold_req      = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_zero_key();
        test_field_extremes();
        test_random_keys(6, 140);
        test_full_pipeline_stall();
        test_steady_stream(250);

        wait_for_results();
        repeat (LATENCY + 8) @(posedge clk);
        $display("Checked %0d blocks (%0d encrypt, %0d decrypt) under %0d key settings,",
                 n_results, n_encrypt, n_decrypt, n_keys);
        $display("with random stalls on both sides and one long output stall.");
        if (errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
